[hdl/query_token_normalize_stem_unit_macros.svh]
// Assertion macros shared by the query token normalizer RTL.
// Each macro takes a label, a clock, a reset, a condition and a consequence.
`ifndef QUERY_TOKEN_NORMALIZE_STEM_UNIT_MACROS_SVH
`define QUERY_TOKEN_NORMALIZE_STEM_UNIT_MACROS_SVH

`ifndef SYNTH
`define QTNS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define QTNS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define QTNS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define QTNS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[hdl/qtns_pkg.sv]
// ----------------------------------------------------------------------------
// qtns_pkg
// Byte classes, character constants and the stopword table of the query
// token normalizer.
// ----------------------------------------------------------------------------
package qtns_pkg;

  typedef logic [1:0]  byte_cls_t;
  typedef logic [39:0] stop_key_t;

  localparam byte_cls_t CLS_APPEND = 2'd0;
  localparam byte_cls_t CLS_DELIM  = 2'd1;
  localparam byte_cls_t CLS_DROP   = 2'd2;

  localparam logic [7:0] CHAR_Y = 8'h79;
  localparam logic [7:0] CHAR_S = 8'h73;

  localparam logic [23:0] SFX_ING = 24'h696E67;
  localparam logic [23:0] SFX_IES = 24'h696573;
  localparam logic [15:0] SFX_ES  = 16'h6573;

  localparam int NUM_STOP = 28;

  // Words are right-justified with the first character in the high byte.
  localparam stop_key_t STOP_TXT [NUM_STOP] = '{
    40'h61,         40'h616E,       40'h616E64,     40'h617265,
    40'h6173,       40'h6174,       40'h6265,       40'h62657374,
    40'h6279,       40'h666F72,     40'h66726F6D,   40'h686F77,
    40'h696E,       40'h6973,       40'h6974,       40'h6F66,
    40'h6F6E,       40'h6F72,       40'h74686174,   40'h746865,
    40'h74686973,   40'h746F,       40'h776173,     40'h77686174,
    40'h7768656E,   40'h7768657265, 40'h7768696368, 40'h77697468
  };

  localparam logic [2:0] STOP_LEN [NUM_STOP] = '{
    3'd1, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd4, 3'd2, 3'd3,
    3'd4, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd3,
    3'd4, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd4
  };

  function automatic byte_cls_t byte_class(input logic [7:0] b);
    byte_cls_t c;
    if (b[7]) begin
      c = CLS_APPEND;
    end else if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
                 (b >= 8'h41 && b <= 8'h5A) || b == 8'h2B || b == 8'h23) begin
      c = CLS_APPEND;
    end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
      c = CLS_DELIM;
    end else if (b >= 8'h21 && b <= 8'h7E) begin
      c = CLS_DELIM;
    end else begin
      c = CLS_DROP;
    end
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_stop(input logic [2:0] n, input stop_key_t k);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_STOP; i++) begin
      if (STOP_LEN[i] == n && STOP_TXT[i] == k) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

[hdl/qtns_ram.sv]
// ----------------------------------------------------------------------------
// qtns_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module qtns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/query_token_normalize_stem_unit.sv]
// ----------------------------------------------------------------------------
// query_token_normalize_stem_unit
// Query tokenizer with lower-casing, stopword removal and suffix stemming.
// ----------------------------------------------------------------------------
// Query bytes enter on the in_* channel, one request per byte, with
// query_last on the final byte of a query. Stemmed token bytes leave on the
// out_* channel, one request per byte; token_end marks the last byte of a
// token and query_end the last result of a query. A query that ends without
// a token byte yields a single request with no_byte set.
// A byte that does not close a token leaves the block idle, and it is ready
// again in the next cycle. A byte that closes a token goes to a stopword and
// suffix check, then through a token RAM read and an output register load for
// each emitted byte; input is held off until the token has been sent, one
// byte per read of the single RAM read port. A stopword passes through the
// check only, and a query end with no token byte, or one ending on a
// stopword, loads its request in an end state.
// The output register lets the next byte be taken while a result waits.
// When the receiver stalls, the block waits with the next byte read and
// accepts no input until the token has been sent.
// Reset empties the current token and the output register; the token RAM
// holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module query_token_normalize_stem_unit #(
  parameter int MAX_TOKEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       query_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       no_byte,
  output logic       token_end,
  output logic       query_end,
  output logic       truncated
);

  import qtns_pkg::*;

  `include "query_token_normalize_stem_unit_macros.svh"

  localparam int LEN_W = $clog2(MAX_TOKEN + 1);
  localparam int AW    = $clog2(MAX_TOKEN);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  logic [2:0]       state;
  logic [LEN_W-1:0] len;
  logic             overflow;
  logic             last_seen;
  stop_key_t        key;
  logic [23:0]      tail;
  logic [LEN_W-1:0] emit_len;
  logic [LEN_W-1:0] cnt;
  logic             ylast;

  logic             accept;
  byte_cls_t        cls;
  logic [7:0]       low_byte;
  logic             store;
  logic             closes;
  logic [LEN_W-1:0] len_after;
  logic             out_free;
  logic             out_load;
  logic             stop_hit;
  logic [LEN_W-1:0] stem_len;
  logic             stem_y;
  logic             last_byte;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cls       = byte_class(in_byte);
  assign low_byte  = to_lower(in_byte);
  assign store     = (cls == CLS_APPEND) && (len < LEN_W'(MAX_TOKEN));
  assign closes    = (cls == CLS_DELIM) || query_last;
  assign len_after = len + LEN_W'(store);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = ((state == S_EMIT) || (state == S_END)) && out_free;
  assign stop_hit  = (len < LEN_W'(6)) && is_stop(len[2:0], key);
  assign last_byte = (cnt == emit_len - LEN_W'(1));
  assign ram_re    = (state == S_READ);

  // Suffix rules, checked in priority order on the last three stored bytes.
  always_comb begin
    stem_len = len;
    stem_y   = 1'b0;
    if (len > LEN_W'(5) && tail == SFX_ING) begin
      stem_len = len - LEN_W'(3);
    end else if (len > LEN_W'(4) && tail == SFX_IES) begin
      stem_len = len - LEN_W'(2);
      stem_y   = 1'b1;
    end else if (len > LEN_W'(3) && tail[15:0] == SFX_ES) begin
      stem_len = len - LEN_W'(2);
    end else if (len > LEN_W'(3) && tail[7:0] == CHAR_S) begin
      stem_len = len - LEN_W'(1);
    end
  end

  qtns_ram #(
    .WIDTH(8),
    .DEPTH(MAX_TOKEN)
  ) u_token_ram (
    .clk  (clk),
    .we   (accept && store),
    .waddr(len[AW-1:0]),
    .wdata(low_byte),
    .re   (ram_re),
    .raddr(cnt[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            len <= len_after;
            if (cls == CLS_APPEND && !store) begin
              overflow <= 1'b1;
            end
            if (closes && len_after != '0) begin
              state <= S_CHECK;
            end else if (query_last) begin
              state <= S_END;
            end
          end
        end
        S_CHECK: begin
          if (stop_hit) begin
            len      <= '0;
            overflow <= 1'b0;
            state    <= last_seen ? S_END : S_IDLE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (last_byte) begin
              len      <= '0;
              overflow <= 1'b0;
              state    <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_END: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers. The key must start from zero for every token, so it
  // is cleared on a stopword hit or a token's last byte; reset clears it too.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (state == S_IDLE && accept && store && len < LEN_W'(5)) begin
      key <= {key[31:0], low_byte};
    end else if ((state == S_CHECK && stop_hit) ||
                 (state == S_EMIT && out_free && last_byte)) begin
      key <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      last_seen <= query_last;
      if (store) begin
        tail <= {tail[15:0], low_byte};
      end
    end
    if (state == S_CHECK) begin
      emit_len <= stem_len;
      ylast    <= stem_y;
      cnt      <= '0;
    end
    if (state == S_EMIT && out_free) begin
      cnt       <= cnt + LEN_W'(1);
      out_byte  <= (ylast && last_byte) ? CHAR_Y : ram_rdata;
      no_byte   <= 1'b0;
      token_end <= last_byte;
      query_end <= last_byte && last_seen;
      truncated <= overflow;
    end
    if (state == S_END && out_free) begin
      out_byte  <= '0;
      no_byte   <= 1'b1;
      token_end <= 1'b0;
      query_end <= 1'b1;
      truncated <= 1'b0;
    end
  end

  `QTNS_ASSERT_IMP(a_overflow_full, clk, rst, overflow, len == LEN_W'(MAX_TOKEN))
  `QTNS_ASSERT_IMP(a_cnt_in_range, clk, rst, (state == S_READ || state == S_EMIT),
                   (cnt < emit_len) && (emit_len <= len))
  `QTNS_ASSERT_NXT(a_close_checks, clk, rst,
                   (accept && closes && len_after != '0), state == S_CHECK)
  `QTNS_ASSERT_NXT(a_emit_loads, clk, rst,
                   (state == S_EMIT && out_free), out_valid && !no_byte)

endmodule
